/* hdl/nrbh_pkg.sv */
// package: widths, constants, register indexes, states and types for the ray/box picker
`default_nettype none
package nrbh_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DirW     = 18;
  localparam int unsigned DistW    = 34;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned FracW    = 16;
  localparam int unsigned DvdW     = DiffW + FracW;
  localparam int unsigned QuotW    = DvdW + 1;
  localparam int unsigned MaxBoxesDefault = 65536;

  // interval limits, +/-100000.0 in Q34.16 (50-bit signed, 16 fraction bits)
  localparam logic signed [QuotW-1:0] TLimit = QuotW'(64'sd6553600000);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDirX    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDirY    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDirZ    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_MERGE,
    ST_FINISH
  } state_e;

  // request into the serial divider
  typedef struct packed {
    logic                    start;
    logic signed [DiffW-1:0] num;
    logic signed [DirW-1:0]  den;
  } div_req_t;

endpackage
`default_nettype wire

/* hdl/nrbh_div.sv */
// bit-serial restoring divider: (num * 65536) / den, truncated toward zero
`default_nettype none
module nrbh_div
  import nrbh_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire div_req_t                req_i,
  output logic                         done_o,
  output logic signed [QuotW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [DirW-1:0]   rem_q, rem_d;
  logic [DirW-1:0]   den_q, den_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic signed [QuotW-1:0] quot_q, quot_d;

  logic [DiffW-1:0]  num_mag;
  logic [DirW-1:0]   den_mag;
  logic [DirW:0]     rem_sh;
  logic              ge;
  logic [DirW:0]     rem_sub;

  // magnitudes of the operands
  assign num_mag = req_i.num[DiffW-1] ? DiffW'(-req_i.num) : DiffW'(req_i.num);
  assign den_mag = req_i.den[DirW-1]  ? DirW'(-req_i.den)  : DirW'(req_i.den);

  // one quotient bit per cycle
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {num_mag, {FracW{1'b0}}};
      rem_d  = '0;
      den_d  = den_mag;
      neg_d  = req_i.num[DiffW-1] ^ req_i.den[DirW-1];
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DirW-1:0] : rem_sh[DirW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quot_d = neg_q ? -$signed({1'b0, dvd_d}) : $signed({1'b0, dvd_d});
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

/* hdl/nearest_ray_box_hit.sv */
// top level: slab test of boxes against a pick ray, tracking the nearest hit
// each axis with a nonzero direction costs two divisions on the shared divider
// the next box is taken once the result is in the output register, which holds it
//   until the transfer
// reset: origin 0, direction (0,0,1.0), pick state cleared, no result pending
`default_nettype none
module nearest_ray_box_hit
  import nrbh_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MaxBoxesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [CoordW-1:0]        cfg_data_i,
  input  wire logic                     box_valid_i,
  output logic                          box_ready_o,
  input  wire logic signed [CoordW-1:0] box_min_x_i,
  input  wire logic signed [CoordW-1:0] box_min_y_i,
  input  wire logic signed [CoordW-1:0] box_min_z_i,
  input  wire logic signed [CoordW-1:0] box_max_x_i,
  input  wire logic signed [CoordW-1:0] box_max_y_i,
  input  wire logic signed [CoordW-1:0] box_max_z_i,
  input  wire logic                     last_box_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output logic                          box_hit_o,
  output logic signed [DistW-1:0]       entry_distance_o,
  output logic                          nearest_found_o,
  output logic [IndexW-1:0]             nearest_index_o,
  output logic signed [DistW-1:0]       nearest_distance_o,
  output logic                          final_result_o
);

  localparam int unsigned CntW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] origin_q [3];
  logic signed [DirW-1:0]   dir_q    [3];
  logic signed [CoordW-1:0] lo_q     [3];
  logic signed [CoordW-1:0] hi_q     [3];
  logic                     last_q;
  logic [1:0]               axis_q;
  logic                     hit_q;
  logic signed [QuotW-1:0]  tnear_q, tfar_q, tlo_q, thi_q;

  logic [CntW-1:0]          count_q;
  logic                     best_valid_q;
  logic [CntW-1:0]          best_index_q;
  logic signed [DistW-1:0]  best_dist_q;

  logic                     res_valid_q;
  logic                     res_hit_q, res_found_q, res_final_q;
  logic signed [DistW-1:0]  res_entry_q, res_best_q;
  logic [IndexW-1:0]        res_index_q;

  div_req_t                 div_req;
  logic                     div_done;
  logic signed [QuotW-1:0]  div_quot;

  logic                     box_xfer, res_load;
  logic signed [CoordW-1:0] org_s, lo_s, hi_s;
  logic signed [DirW-1:0]   dir_s;
  logic                     dir_zero, in_slab;
  logic signed [QuotW-1:0]  tmax, nnear, nfar;
  logic                     merge_miss, take_best;
  logic signed [DistW-1:0]  tnear34;

  nrbh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // per-axis operand select
  assign org_s    = origin_q[axis_q];
  assign dir_s    = dir_q[axis_q];
  assign lo_s     = lo_q[axis_q];
  assign hi_s     = hi_q[axis_q];
  assign dir_zero = (dir_s == '0);
  assign in_slab  = (org_s > lo_s) && (org_s < hi_s);

  // order the pair and narrow the interval
  assign tmax       = (tlo_q > div_quot) ? tlo_q : div_quot;
  assign nnear      = (thi_q > tnear_q) ? thi_q : tnear_q;
  assign nfar       = (tmax < tfar_q) ? tmax : tfar_q;
  assign merge_miss = (nnear > nfar) || (nfar < 0);

  assign tnear34   = tnear_q[DistW-1:0];
  assign take_best = hit_q && (!best_valid_q || (tnear34 < best_dist_q));

  assign box_xfer = box_valid_i && box_ready_o;
  assign res_load = (state_q == ST_FINISH) && (!res_valid_q || res_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (box_valid_i) state_d = ST_AXIS;
      ST_AXIS: begin
        if (!dir_zero) state_d = ST_DIV_LO;
        else if (!in_slab || axis_q == 2'd2) state_d = ST_FINISH;
      end
      ST_DIV_LO: if (div_done) state_d = ST_DIV_HI;
      ST_DIV_HI: if (div_done) state_d = ST_MERGE;
      ST_MERGE: begin
        if (merge_miss || axis_q == 2'd2) state_d = ST_FINISH;
        else state_d = ST_AXIS;
      end
      ST_FINISH: if (res_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    box_ready_o   = (state_q == ST_IDLE);
    div_req.start = 1'b0;
    div_req.num   = DiffW'(lo_s) - DiffW'(org_s);
    div_req.den   = dir_s;
    unique case (state_q)
      ST_AXIS:   div_req.start = !dir_zero;
      ST_DIV_LO: begin
        div_req.start = div_done;
        div_req.num   = DiffW'(hi_s) - DiffW'(org_s);
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= DirW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOriginX: origin_q[0] <= cfg_data_i;
        RegOriginY: origin_q[1] <= cfg_data_i;
        RegOriginZ: origin_q[2] <= cfg_data_i;
        RegDirX:    dir_q[0]    <= cfg_data_i[DirW-1:0];
        RegDirY:    dir_q[1]    <= cfg_data_i[DirW-1:0];
        RegDirZ:    dir_q[2]    <= cfg_data_i[DirW-1:0];
        default: ;
      endcase
    end
  end

  // box capture and slab datapath
  always_ff @(posedge clk_i) begin
    if (box_xfer) begin
      lo_q[0] <= box_min_x_i;
      lo_q[1] <= box_min_y_i;
      lo_q[2] <= box_min_z_i;
      hi_q[0] <= box_max_x_i;
      hi_q[1] <= box_max_y_i;
      hi_q[2] <= box_max_z_i;
      last_q  <= last_box_i;
      axis_q  <= '0;
      hit_q   <= 1'b1;
      tnear_q <= -TLimit;
      tfar_q  <= TLimit;
    end
    if (state_q == ST_AXIS && dir_zero) begin
      if (!in_slab) hit_q <= 1'b0;
      else if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
    end
    if (state_q == ST_DIV_LO && div_done) tlo_q <= div_quot;
    if (state_q == ST_DIV_HI && div_done) begin
      thi_q <= (tlo_q > div_quot) ? div_quot : tlo_q;
      tlo_q <= (tlo_q > div_quot) ? tlo_q : div_quot;
    end
    if (state_q == ST_MERGE) begin
      tnear_q <= nnear;
      tfar_q  <= nfar;
      if (merge_miss) hit_q <= 1'b0;
      else if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
    end
  end

  // pick tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      best_valid_q <= 1'b0;
      best_index_q <= '0;
      best_dist_q  <= '0;
    end else if (res_load) begin
      if (last_q) begin
        count_q      <= '0;
        best_valid_q <= 1'b0;
        best_index_q <= '0;
        best_dist_q  <= '0;
      end else begin
        count_q <= (count_q == CntW'(MAX_BOXES - 1)) ? '0 : count_q + 1'b1;
        if (take_best) begin
          best_valid_q <= 1'b1;
          best_index_q <= count_q;
          best_dist_q  <= tnear34;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (res_load) res_valid_q <= 1'b1;
    else if (res_ready_i) res_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_hit_q   <= hit_q;
      res_entry_q <= hit_q ? tnear34 : '0;
      res_found_q <= take_best || best_valid_q;
      res_index_q <= take_best ? IndexW'(count_q) : IndexW'(best_index_q);
      res_best_q  <= take_best ? tnear34 : best_dist_q;
      res_final_q <= last_q;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign box_hit_o          = res_hit_q;
  assign entry_distance_o   = res_entry_q;
  assign nearest_found_o    = res_found_q;
  assign nearest_index_o    = res_index_q;
  assign nearest_distance_o = res_best_q;
  assign final_result_o     = res_final_q;

endmodule
`default_nettype wire
